>>> src/deblk_pkg.sv
// Shared types, register codes and constants for the edge deblocking filter.
package deblk_pkg;

  localparam int PIX_W              = 16;
  localparam int THR_W              = 16;
  localparam int NUM_PX             = 6;
  localparam int PIXEL_BITS_DEFAULT = 16;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_STRONG_MODE = 3'd0,
    REG_EDGE_THR    = 3'd1,
    REG_P_SIDE_THR  = 3'd2,
    REG_Q_OUTER_THR = 3'd3,
    REG_Q_INNER_THR = 3'd4,
    REG_PIXEL_MAX   = 3'd5
  } cfg_index_t;

  // Register reset values
  localparam logic             RST_STRONG_MODE = 1'b1;
  localparam logic [THR_W-1:0] RST_EDGE_THR    = 16'd24;
  localparam logic [THR_W-1:0] RST_P_SIDE_THR  = 16'd12;
  localparam logic [THR_W-1:0] RST_Q_OUTER_THR = 16'd12;
  localparam logic [THR_W-1:0] RST_Q_INNER_THR = 16'd12;
  localparam logic [PIX_W-1:0] RST_PIXEL_MAX   = 16'd255;

  typedef struct packed {
    cfg_index_t       index;
    logic [THR_W-1:0] value;
  } cfg_write_t;

  typedef struct packed {
    logic [PIX_W-1:0] p2;
    logic [PIX_W-1:0] p1;
    logic [PIX_W-1:0] p0;
    logic [PIX_W-1:0] q0;
    logic [PIX_W-1:0] q1;
    logic [PIX_W-1:0] q2;
  } line_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_p2;
    logic [PIX_W-1:0] out_p1;
    logic [PIX_W-1:0] out_p0;
    logic [PIX_W-1:0] out_q0;
    logic [PIX_W-1:0] out_q1;
    logic [PIX_W-1:0] out_q2;
    logic             applied;
  } result_item_t;

endpackage

>>> src/deblk_stream_if.sv
// Valid/ready channel interface carrying one payload per transaction.
interface deblk_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/edge_deblock_filter_core.sv
// Top level of the edge deblocking filter: config registers and four-stage filter pipeline.
//
//   channel   role    payload          transaction when
//   cfg       sink    cfg_write_t      cfg.valid && cfg.ready (ready is always high)
//   pixels    sink    line_item_t      pixels.valid && pixels.ready
//   result    source   result_item_t   result.valid && result.ready
//
// An accepted line passes through four registered stages to its result; one line per
// clock is sustained while result.ready is high. The stages are: edge and side
// differences, threshold tests and delta fractions, filtered sums, clipping into the
// output register. Each stage holds its line while the stage after it is full and
// stalled, so bubbles are squeezed out and input is taken while a result waits.
// rst is synchronous; it empties the pipeline and restores the register defaults.
module edge_deblock_filter_core
  import deblk_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  deblk_stream_if.sink   cfg,
  deblk_stream_if.sink   pixels,
  deblk_stream_if.source result
);

  localparam logic [PIX_W-1:0] BIT_MAX = PIX_W'((32'd1 << PIXEL_BITS) - 32'd1);

  // Configuration registers
  logic             strong_mode;
  logic [THR_W-1:0] edge_thr;
  logic [THR_W-1:0] p_side_thr;
  logic [THR_W-1:0] q_outer_thr;
  logic [THR_W-1:0] q_inner_thr;
  logic [PIX_W-1:0] clip_hi;

  // Stage valids and stage load enables
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  // Stage 1: pixels, delta, absolute differences
  logic        [PIX_W-1:0] s1_px [NUM_PX];
  logic signed [PIX_W:0]   s1_delta;
  logic        [PIX_W-1:0] s1_abs_qp, s1_abs_pp, s1_abs_q01, s1_abs_q12;

  // Stage 2: pass flag and delta fractions
  logic        [PIX_W-1:0] s2_px [NUM_PX];
  logic                    s2_pass;
  logic                    s2_strong;
  logic signed [PIX_W:0]   s2_frac2, s2_frac4, s2_frac8;

  // Stage 3: unclipped sums and filter mask
  logic        [PIX_W-1:0] s3_px [NUM_PX];
  logic signed [PIX_W+1:0] s3_sum [NUM_PX];
  logic        [NUM_PX-1:0] s3_filt;
  logic                    s3_pass;

  // Stage 4: output register
  logic [PIX_W-1:0] s4_px [NUM_PX];
  logic             s4_pass;

  // Combinational stage inputs
  logic        [PIX_W-1:0] in_px [NUM_PX];
  logic                    pass_c;
  logic signed [PIX_W:0]   frac_sel [NUM_PX];

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    logic signed [PIX_W:0] d;
    logic signed [PIX_W:0] nd;
    d  = $signed({1'b0, a}) - $signed({1'b0, b});
    nd = -d;
    return d[PIX_W] ? nd[PIX_W-1:0] : d[PIX_W-1:0];
  endfunction

  // Write configuration registers; clip bound is limited to the pixel depth
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      strong_mode <= RST_STRONG_MODE;
      edge_thr    <= RST_EDGE_THR;
      p_side_thr  <= RST_P_SIDE_THR;
      q_outer_thr <= RST_Q_OUTER_THR;
      q_inner_thr <= RST_Q_INNER_THR;
      clip_hi     <= (RST_PIXEL_MAX < BIT_MAX) ? RST_PIXEL_MAX : BIT_MAX;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_STRONG_MODE: strong_mode <= cfg.data.value[0];
        REG_EDGE_THR:    edge_thr    <= cfg.data.value;
        REG_P_SIDE_THR:  p_side_thr  <= cfg.data.value;
        REG_Q_OUTER_THR: q_outer_thr <= cfg.data.value;
        REG_Q_INNER_THR: q_inner_thr <= cfg.data.value;
        REG_PIXEL_MAX:   clip_hi     <= (cfg.data.value < BIT_MAX) ? cfg.data.value : BIT_MAX;
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or the next one advances
  assign rdy4         = !v4 || result.ready;
  assign rdy3         = !v3 || rdy4;
  assign rdy2         = !v2 || rdy3;
  assign rdy1         = !v1 || rdy2;
  assign pixels.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= pixels.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Unpack the line, p2 first
  assign in_px[0] = pixels.data.p2;
  assign in_px[1] = pixels.data.p1;
  assign in_px[2] = pixels.data.p0;
  assign in_px[3] = pixels.data.q0;
  assign in_px[4] = pixels.data.q1;
  assign in_px[5] = pixels.data.q2;

  // Stage 1: take differences across and beside the edge
  always_ff @(posedge clk) begin
    if (rdy1 && pixels.valid) begin
      s1_px      <= in_px;
      s1_delta   <= $signed({1'b0, pixels.data.q0}) - $signed({1'b0, pixels.data.p0});
      s1_abs_qp  <= abs_diff(pixels.data.q0, pixels.data.p0);
      s1_abs_pp  <= abs_diff(pixels.data.p0, pixels.data.p1);
      s1_abs_q01 <= abs_diff(pixels.data.q0, pixels.data.q1);
      s1_abs_q12 <= abs_diff(pixels.data.q1, pixels.data.q2);
    end
  end

  // Stage 2: threshold tests and fractions truncated toward zero
  always_comb begin
    pass_c = (s1_abs_qp < edge_thr) && (s1_abs_pp < p_side_thr);
    if (strong_mode) begin
      pass_c = pass_c && (s1_abs_q12 < q_outer_thr) && (s1_abs_q01 < q_inner_thr);
    end else begin
      pass_c = pass_c && (s1_abs_q01 < q_outer_thr);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      s2_px     <= s1_px;
      s2_pass   <= pass_c;
      s2_strong <= strong_mode;
      s2_frac2  <= (s1_delta + $signed({{PIX_W{1'b0}}, s1_delta[PIX_W]})) >>> 1;
      s2_frac4  <= (s1_delta + $signed({{(PIX_W-1){1'b0}}, {2{s1_delta[PIX_W]}}})) >>> 2;
      s2_frac8  <= (s1_delta + $signed({{(PIX_W-2){1'b0}}, {3{s1_delta[PIX_W]}}})) >>> 3;
    end
  end

  // Stage 3: pick each pixel's fraction and form the filtered sums
  always_comb begin
    frac_sel[0] = s2_frac8;
    frac_sel[1] = s2_strong ? s2_frac4 : s2_frac8;
    frac_sel[2] = s2_frac2;
    frac_sel[3] = s2_frac2;
    frac_sel[4] = s2_strong ? s2_frac4 : s2_frac8;
    frac_sel[5] = s2_frac8;
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      s3_px   <= s2_px;
      s3_pass <= s2_pass;
      if (!s2_pass) begin
        s3_filt <= '0;
      end else if (s2_strong) begin
        s3_filt <= '1;
      end else begin
        s3_filt <= 6'b011110;
      end
      for (int i = 0; i < NUM_PX; i++) begin
        if (i < NUM_PX / 2) begin
          s3_sum[i] <= $signed({2'b00, s2_px[i]}) + $signed({frac_sel[i][PIX_W], frac_sel[i]});
        end else begin
          s3_sum[i] <= $signed({2'b00, s2_px[i]}) - $signed({frac_sel[i][PIX_W], frac_sel[i]});
        end
      end
    end
  end

  // Stage 4: clip filtered pixels, pass the rest through
  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      s4_pass <= s3_pass;
      for (int i = 0; i < NUM_PX; i++) begin
        if (!s3_filt[i]) begin
          s4_px[i] <= s3_px[i];
        end else if (s3_sum[i][PIX_W+1]) begin
          s4_px[i] <= '0;
        end else if (s3_sum[i][PIX_W:0] > {1'b0, clip_hi}) begin
          s4_px[i] <= clip_hi;
        end else begin
          s4_px[i] <= s3_sum[i][PIX_W-1:0];
        end
      end
    end
  end

  assign result.valid        = v4;
  assign result.data.out_p2  = s4_px[0];
  assign result.data.out_p1  = s4_px[1];
  assign result.data.out_p0  = s4_px[2];
  assign result.data.out_q0  = s4_px[3];
  assign result.data.out_q1  = s4_px[4];
  assign result.data.out_q2  = s4_px[5];
  assign result.data.applied = s4_pass;

  // Clip bound never exceeds the pixel depth
  a_clip_bound: assert property (@(posedge clk) disable iff (rst) clip_hi <= BIT_MAX)
    else $error("clip bound above pixel depth");

  // A filtered line never shows p0 or q0 above the clip bound
  a_applied_clip: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.applied |->
      result.data.out_p0 <= clip_hi && result.data.out_q0 <= clip_hi)
    else $error("filtered edge pixel above clip bound");

  // A line that failed the tests gets no filtered pixel
  a_mask_pass: assert property (@(posedge clk) disable iff (rst)
    v3 && !s3_pass |-> s3_filt == '0)
    else $error("filter mask set on failed line");

  // A stage held by a stalled successor keeps its line
  a_stage3_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && !rdy4 |=> v3 && $stable(s3_pass) && $stable(s3_filt))
    else $error("stage 3 lost its line under stall");

endmodule
